// File: design/two_level_otsu_threshold_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the two-level Otsu threshold block
// Implication checks sampled on i_clk, disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef TWO_LEVEL_OTSU_THRESHOLD_DEFINES_SVH
`define TWO_LEVEL_OTSU_THRESHOLD_DEFINES_SVH

// same-cycle implication
`define OTSU_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define OTSU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/otsu_pkg.sv
// ----------------------------------------------------------------------------
// otsu_pkg
// Types and constants shared by the two-level Otsu threshold block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package otsu_pkg;

    localparam int LVL_W     = 8;
    localparam int LEVELS    = 256;
    localparam int CNT_W     = 21;
    localparam int SUM_W     = 28;
    localparam int FRAC_BITS = 8;
    localparam int SQ_W      = 2 * SUM_W;
    localparam int NUM_W     = SQ_W + FRAC_BITS;
    localparam int QUOT_W    = 2 * LVL_W + CNT_W - 1 + FRAC_BITS;
    localparam int QCNT_W    = $clog2(QUOT_W);
    localparam int SCORE_W   = QUOT_W + 2;

    localparam logic [CNT_W-1:0] MAX_PIXELS = CNT_W'(1048576);
    localparam logic [LVL_W-1:0] LVL_LAST   = LVL_W'(LEVELS - 1);

    typedef struct packed {
        logic [LVL_W-1:0] saliency_level;
        logic             last_pixel;
    } t_in;

    typedef struct packed {
        logic [LVL_W-1:0] thresh_low;
        logic [LVL_W-1:0] thresh_high;
        logic             overflow;
    } t_out;

    typedef struct packed {
        logic             we;
        logic [LVL_W-1:0] addr;
        logic [CNT_W-1:0] data;
    } t_hist_wr;

    typedef enum logic [1:0] {
        DV_IDLE,
        DV_SQ,
        DV_RUN
    } t_div_state;

    typedef enum logic [3:0] {
        ST_ACC,
        ST_DRAIN,
        ST_RD1,
        ST_AD1,
        ST_CHK1,
        ST_DIV0,
        ST_RD2,
        ST_AD2,
        ST_CHK2,
        ST_DIV1,
        ST_DIV2,
        ST_CMP,
        ST_FIN
    } t_state;

endpackage

// File: design/otsu_hist.sv
// ----------------------------------------------------------------------------
// otsu_hist
// Histogram bin memory, one write and one registered read port per cycle.
// Per-bin valid bits make a cleared bin read as zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module otsu_hist (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_clr,
    input  otsu_pkg::t_hist_wr          i_wr,
    input  logic [otsu_pkg::LVL_W-1:0]  i_raddr,
    output logic [otsu_pkg::CNT_W-1:0]  o_rdata
);

    logic [otsu_pkg::CNT_W-1:0]  r_mem [0:otsu_pkg::LEVELS-1];
    logic [otsu_pkg::LEVELS-1:0] r_vld;
    logic [otsu_pkg::CNT_W-1:0]  r_rd;
    logic                        r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr.we) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
        r_rd     <= r_mem[i_raddr];
        r_rd_vld <= r_vld[i_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_vld <= '0;
        end else if (i_wr.we) begin
            r_vld[i_wr.addr] <= 1'b1;
        end
    end

    assign o_rdata = r_rd_vld ? r_rd : '0;

endmodule

// File: design/otsu_div.sv
// ----------------------------------------------------------------------------
// otsu_div
// Class term unit: floor(s*s*2^FRAC_BITS / c), one square then one
// restoring quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module otsu_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [otsu_pkg::SUM_W-1:0]   i_s,
    input  logic [otsu_pkg::CNT_W-1:0]   i_c,
    output logic                         o_done,
    output logic [otsu_pkg::QUOT_W-1:0]  o_quot
);

    otsu_pkg::t_div_state              r_state, n_state;
    logic [otsu_pkg::SUM_W-1:0]        r_s;
    logic [otsu_pkg::CNT_W-1:0]        r_c;
    logic [otsu_pkg::CNT_W-1:0]        r_rem;
    logic [otsu_pkg::QUOT_W-1:0]       r_num;
    logic [otsu_pkg::QCNT_W-1:0]       r_cnt;
    logic                              r_done;
    logic [otsu_pkg::SQ_W-1:0]         sq;
    logic [otsu_pkg::NUM_W-1:0]        num;
    logic [otsu_pkg::CNT_W:0]          trial;
    logic                              ge;
    logic                              last_bit;

    assign sq       = r_s * r_s;
    assign num      = {sq, {otsu_pkg::FRAC_BITS{1'b0}}};
    assign trial    = {r_rem, r_num[otsu_pkg::QUOT_W-1]};
    assign ge       = trial >= {1'b0, r_c};
    assign last_bit = r_cnt == otsu_pkg::QCNT_W'(otsu_pkg::QUOT_W - 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= otsu_pkg::DV_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == otsu_pkg::DV_RUN) && last_bit;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            otsu_pkg::DV_IDLE: begin
                if (i_start) n_state = otsu_pkg::DV_SQ;
            end
            otsu_pkg::DV_SQ: begin
                n_state = otsu_pkg::DV_RUN;
            end
            otsu_pkg::DV_RUN: begin
                if (last_bit) n_state = otsu_pkg::DV_IDLE;
            end
            default: n_state = otsu_pkg::DV_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            otsu_pkg::DV_IDLE: begin
                r_s <= i_s;
                r_c <= i_c;
            end
            otsu_pkg::DV_SQ: begin
                r_rem <= otsu_pkg::CNT_W'(num[otsu_pkg::NUM_W-1:otsu_pkg::QUOT_W]);
                r_num <= num[otsu_pkg::QUOT_W-1:0];
                r_cnt <= '0;
            end
            otsu_pkg::DV_RUN: begin
                r_rem <= ge ? otsu_pkg::CNT_W'(trial - {1'b0, r_c})
                            : otsu_pkg::CNT_W'(trial);
                r_num <= {r_num[otsu_pkg::QUOT_W-2:0], ge};
                r_cnt <= r_cnt + 1'b1;
            end
            default: ;
        endcase
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule

// File: design/two_level_otsu_threshold.sv
// ----------------------------------------------------------------------------
// two_level_otsu_threshold
// Histogram of 8-bit saliency levels and two-level Otsu threshold search.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel i_valid/o_ready carries one pixel item (level, last flag).
//   Pixels are taken one per cycle while the block is collecting; a pixel
//   beyond 2^20 per frame is dropped and reported in the overflow bit.
//   The item marked last starts the threshold search; o_ready is low until
//   the result has been loaded into the output register.
//   Search: one drain state, then read, add and check states per first
//   threshold plus the class zero term from the divider when that class is
//   nonempty, and read, add and check states per second threshold plus two
//   passes through the shared divider and a compare for each pair whose
//   three classes are nonempty.
//   Output channel o_valid/i_ready carries one result item per frame. The
//   result register holds while i_ready is low; pixels of the next frame are
//   accepted meanwhile, and the next search waits at its end for the register.
//   Reset (synchronous, active low) clears counts, sums and the histogram at
//   once; the block is ready as soon as reset is released.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "two_level_otsu_threshold_defines.svh"

module two_level_otsu_threshold (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  otsu_pkg::t_in   i_data,
    output logic            o_valid,
    input  logic            i_ready,
    output otsu_pkg::t_out  o_data
);

    otsu_pkg::t_state                 r_state, n_state;
    otsu_pkg::t_hist_wr               hist_wr;
    logic [otsu_pkg::LVL_W-1:0]       raddr;
    logic [otsu_pkg::CNT_W-1:0]       rdata;

    logic                             accept;
    logic                             counted;
    logic                             fin_go;

    logic                             r_w_v;
    logic [otsu_pkg::LVL_W-1:0]       r_w_addr;
    logic                             r_fwd;
    logic [otsu_pkg::CNT_W-1:0]       r_last_w;
    logic [otsu_pkg::CNT_W-1:0]       wdata;

    logic [otsu_pkg::CNT_W-1:0]       r_total;
    logic [otsu_pkg::SUM_W-1:0]       r_sum;
    logic                             r_drop;

    logic [otsu_pkg::LVL_W-1:0]       r_t1, r_t2;
    logic [otsu_pkg::CNT_W-1:0]       r_c0, r_c1, r_c2;
    logic [otsu_pkg::SUM_W-1:0]       r_s0, r_s1, r_s2;
    logic [otsu_pkg::CNT_W-1:0]       c2;
    logic [otsu_pkg::SUM_W-1:0]       s2;
    logic [otsu_pkg::SUM_W-1:0]       prod;
    logic [otsu_pkg::QUOT_W-1:0]      r_term0, r_term1;
    logic [otsu_pkg::SCORE_W-1:0]     r_score, r_best;
    logic [otsu_pkg::LVL_W-1:0]       r_best_lo, r_best_hi;

    logic                             div_start;
    logic [otsu_pkg::SUM_W-1:0]       div_s;
    logic [otsu_pkg::CNT_W-1:0]       div_c;
    logic                             div_done;
    logic [otsu_pkg::QUOT_W-1:0]      div_q;

    logic                             r_o_valid;
    otsu_pkg::t_out                   r_out;

    logic                             t1_last, t2_last;

    assign o_ready = r_state == otsu_pkg::ST_ACC;
    assign accept  = i_valid && o_ready;
    assign counted = accept && (r_total != otsu_pkg::MAX_PIXELS);
    assign fin_go  = (r_state == otsu_pkg::ST_FIN) && (!r_o_valid || i_ready);
    assign t1_last = r_t1 == otsu_pkg::LVL_LAST;
    assign t2_last = r_t2 == otsu_pkg::LVL_LAST;

    // bin increment: read at accept, write in the following cycle, forward on back-to-back hit
    assign wdata   = (r_fwd ? r_last_w : rdata) + 1'b1;
    assign hist_wr = '{we: r_w_v, addr: r_w_addr, data: wdata};

    assign raddr = (r_state == otsu_pkg::ST_ACC) ? i_data.saliency_level :
                   (r_state == otsu_pkg::ST_RD1) ? r_t1 : r_t2;

    assign c2   = r_total - r_c0 - r_c1;
    assign s2   = r_sum - r_s0 - r_s1;
    assign prod = ((r_state == otsu_pkg::ST_AD1) ? otsu_pkg::SUM_W'(r_t1)
                                                 : otsu_pkg::SUM_W'(r_t2))
                  * otsu_pkg::SUM_W'(rdata);

    otsu_hist u_hist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (fin_go),
        .i_wr    (hist_wr),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    otsu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_s     (div_s),
        .i_c     (div_c),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= otsu_pkg::ST_ACC;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        div_start = 1'b0;
        div_s     = r_s1;
        div_c     = r_c1;
        unique case (r_state)
            otsu_pkg::ST_ACC: begin
                if (accept && i_data.last_pixel) n_state = otsu_pkg::ST_DRAIN;
            end
            otsu_pkg::ST_DRAIN: n_state = otsu_pkg::ST_RD1;
            otsu_pkg::ST_RD1:   n_state = otsu_pkg::ST_AD1;
            otsu_pkg::ST_AD1:   n_state = otsu_pkg::ST_CHK1;
            otsu_pkg::ST_CHK1: begin
                if (t1_last) begin
                    n_state = otsu_pkg::ST_FIN;
                end else if (r_c0 == '0) begin
                    n_state = otsu_pkg::ST_RD1;
                end else begin
                    div_start = 1'b1;
                    div_s     = r_s0;
                    div_c     = r_c0;
                    n_state   = otsu_pkg::ST_DIV0;
                end
            end
            otsu_pkg::ST_DIV0: begin
                if (div_done) n_state = otsu_pkg::ST_RD2;
            end
            otsu_pkg::ST_RD2: n_state = otsu_pkg::ST_AD2;
            otsu_pkg::ST_AD2: n_state = otsu_pkg::ST_CHK2;
            otsu_pkg::ST_CHK2: begin
                if (c2 == '0 || (r_c1 == '0 && t2_last)) begin
                    n_state = t1_last ? otsu_pkg::ST_FIN : otsu_pkg::ST_RD1;
                end else if (r_c1 == '0) begin
                    n_state = otsu_pkg::ST_RD2;
                end else begin
                    div_start = 1'b1;
                    n_state   = otsu_pkg::ST_DIV1;
                end
            end
            otsu_pkg::ST_DIV1: begin
                if (div_done) begin
                    div_start = 1'b1;
                    div_s     = r_s2;
                    div_c     = r_c2;
                    n_state   = otsu_pkg::ST_DIV2;
                end
            end
            otsu_pkg::ST_DIV2: begin
                if (div_done) n_state = otsu_pkg::ST_CMP;
            end
            otsu_pkg::ST_CMP: begin
                if (!t2_last) begin
                    n_state = otsu_pkg::ST_RD2;
                end else begin
                    n_state = t1_last ? otsu_pkg::ST_FIN : otsu_pkg::ST_RD1;
                end
            end
            otsu_pkg::ST_FIN: begin
                if (fin_go) n_state = otsu_pkg::ST_ACC;
            end
            default: n_state = otsu_pkg::ST_ACC;
        endcase
    end

    // pixel intake
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w_v   <= 1'b0;
            r_fwd   <= 1'b0;
            r_total <= '0;
            r_sum   <= '0;
            r_drop  <= 1'b0;
        end else begin
            r_w_v <= counted;
            r_fwd <= counted && r_w_v && (r_w_addr == i_data.saliency_level);
            if (fin_go) begin
                r_total <= '0;
                r_sum   <= '0;
                r_drop  <= 1'b0;
            end else if (counted) begin
                r_total <= r_total + 1'b1;
                r_sum   <= r_sum + otsu_pkg::SUM_W'(i_data.saliency_level);
            end else if (accept) begin
                r_drop <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_w_addr <= i_data.saliency_level;
        if (r_w_v) r_last_w <= wdata;
    end

    // search datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            otsu_pkg::ST_DRAIN: begin
                r_t1      <= '0;
                r_c0      <= '0;
                r_s0      <= '0;
                r_best    <= '0;
                r_best_lo <= '0;
                r_best_hi <= '0;
            end
            otsu_pkg::ST_AD1: begin
                r_c0 <= r_c0 + rdata;
                r_s0 <= r_s0 + prod;
            end
            otsu_pkg::ST_AD2: begin
                r_c1 <= r_c1 + rdata;
                r_s1 <= r_s1 + prod;
            end
            otsu_pkg::ST_CHK2: begin
                r_c2 <= c2;
                r_s2 <= s2;
            end
            otsu_pkg::ST_DIV0: begin
                if (div_done) begin
                    r_term0 <= div_q;
                    r_t2    <= r_t1 + 1'b1;
                    r_c1    <= '0;
                    r_s1    <= '0;
                end
            end
            otsu_pkg::ST_DIV1: begin
                if (div_done) r_term1 <= div_q;
            end
            otsu_pkg::ST_DIV2: begin
                if (div_done) begin
                    r_score <= otsu_pkg::SCORE_W'(r_term0) + otsu_pkg::SCORE_W'(r_term1)
                             + otsu_pkg::SCORE_W'(div_q);
                end
            end
            otsu_pkg::ST_CMP: begin
                if (r_score > r_best) begin
                    r_best    <= r_score;
                    r_best_lo <= r_t1;
                    r_best_hi <= r_t2;
                end
            end
            default: ;
        endcase
        if ((r_state == otsu_pkg::ST_CHK2 || r_state == otsu_pkg::ST_CMP)
                && n_state == otsu_pkg::ST_RD2) begin
            r_t2 <= r_t2 + 1'b1;
        end
        if (r_state != otsu_pkg::ST_DRAIN && r_state != otsu_pkg::ST_RD1
                && n_state == otsu_pkg::ST_RD1) begin
            r_t1 <= r_t1 + 1'b1;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (fin_go) begin
            r_o_valid <= 1'b1;
        end else if (i_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_go) begin
            r_out <= '{thresh_low: r_best_lo, thresh_high: r_best_hi, overflow: r_drop};
        end
    end

    assign o_valid = r_o_valid;
    assign o_data  = r_out;

    `OTSU_ASSERT_SAME(a_no_write_in_search,
        (r_state != otsu_pkg::ST_ACC && r_state != otsu_pkg::ST_DRAIN), !r_w_v,
        "histogram write during search")
    `OTSU_ASSERT_NEXT(a_fin_loads_result, fin_go,
        o_valid && r_state == otsu_pkg::ST_ACC && r_total == '0,
        "result not loaded at end of search")
    `OTSU_ASSERT_SAME(a_total_bound, 1'b1, r_total <= otsu_pkg::MAX_PIXELS,
        "pixel total above limit")
    `OTSU_ASSERT_SAME(a_pair_order, r_state == otsu_pkg::ST_FIN && r_best != '0,
        r_best_lo < r_best_hi,
        "best threshold pair out of order")

endmodule

// File: dv/two_level_otsu_threshold_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_level_otsu_threshold_tb
// Streams pixel frames into the block and checks each (t1, t2, overflow)
// result against a histogram predictor that runs the exhaustive pair search.
// ----------------------------------------------------------------------------

module two_level_otsu_threshold_tb;

    typedef struct {
        otsu_pkg::t_in item;
        bit            drain_first;
        bit            quiet;
    } t_pending;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_valid;
    logic             o_ready;
    otsu_pkg::t_in    i_data;
    logic             o_valid;
    logic             i_ready;
    otsu_pkg::t_out   o_data;

    t_pending         pending_q[$];
    otsu_pkg::t_out   expected_q[$];
    int       fail_count;
    int       gap;
    bit       pix_taken;
    bit       out_busy_mode;

    int unsigned    bin_count[otsu_pkg::LEVELS];
    int unsigned    frame_pixels;
    longint unsigned frame_sum;
    bit             frame_dropped;

    two_level_otsu_threshold uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    task automatic report_mismatch(input string what);
        $display("mismatch @%0t: %s", $realtime, what);
        fail_count++;
    endtask

    function automatic longint unsigned class_score(longint unsigned s, longint unsigned c);
        longint unsigned sq;
        sq = s * s;
        return ((sq / c) << otsu_pkg::FRAC_BITS) + (((sq % c) << otsu_pkg::FRAC_BITS) / c);
    endfunction

    function automatic void clear_histogram();
        foreach (bin_count[k]) bin_count[k] = 0;
        frame_pixels  = 0;
        frame_sum     = 0;
        frame_dropped = 0;
    endfunction

    // adds one pixel; on the last pixel pushes the expected thresholds
    function automatic void add_pixel(otsu_pkg::t_in px);
        longint unsigned c0, s0, c1, s1, c2, s2, score, best;
        otsu_pkg::t_out res;
        c0 = 0;
        s0 = 0;
        best = 0;
        res = '0;
        if (frame_pixels >= int'(otsu_pkg::MAX_PIXELS)) begin
            frame_dropped = 1;
        end else begin
            bin_count[px.saliency_level]++;
            frame_pixels++;
            frame_sum += px.saliency_level;
        end
        if (!px.last_pixel) return;
        for (int t1 = 0; t1 < otsu_pkg::LEVELS; t1++) begin
            c0 += bin_count[t1];
            s0 += longint'(t1) * bin_count[t1];
            c1 = 0;
            s1 = 0;
            for (int t2 = t1 + 1; t2 < otsu_pkg::LEVELS; t2++) begin
                c1 += bin_count[t2];
                s1 += longint'(t2) * bin_count[t2];
                c2 = frame_pixels - c0 - c1;
                s2 = frame_sum - s0 - s1;
                if (c2 == 0) break;
                if (c0 == 0 || c1 == 0) continue;
                score = class_score(s0, c0) + class_score(s1, c1) + class_score(s2, c2);
                if (score > best) begin
                    best = score;
                    res.thresh_low  = otsu_pkg::LVL_W'(t1);
                    res.thresh_high = otsu_pkg::LVL_W'(t2);
                end
            end
        end
        res.overflow = frame_dropped;
        expected_q.push_back(res);
        clear_histogram();
    endfunction

    function automatic int draw_gap();
        int r;
        r = $urandom_range(99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(3, 1);
        return $urandom_range(60, 10);
    endfunction

    function automatic void queue_pixel(int lvl, bit last, bit drain, bit quiet);
        t_pending p;
        p.item.saliency_level = otsu_pkg::LVL_W'(lvl);
        p.item.last_pixel     = last;
        p.drain_first         = drain;
        p.quiet               = quiet;
        pending_q.push_back(p);
    endfunction

    function automatic void queue_frame(int levels[$], bit drain, bit quiet);
        foreach (levels[k])
            queue_pixel(levels[k], k == levels.size() - 1, drain && k == 0, quiet);
    endfunction

    // sender
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !pix_taken) begin
        end else if (gap > 0) begin
            i_valid <= 1'b0;
            gap <= gap - 1;
        end else if (pending_q.size() > 0 && !(pending_q[0].drain_first
                     && (expected_q.size() != 0 || i_valid))) begin
            i_data  <= pending_q[0].item;
            i_valid <= 1'b1;
            gap <= pending_q[0].quiet ? 0 : draw_gap();
            void'(pending_q.pop_front());
        end else begin
            i_valid <= 1'b0;
        end
    end

    // receiver backpressure
    always @(negedge i_clk) begin
        if ($urandom_range(199) == 0) out_busy_mode <= !out_busy_mode;
        if (!out_busy_mode) i_ready <= 1'b1;
        else if ($urandom_range(19) == 0) i_ready <= ($urandom_range(29) == 0);
        else i_ready <= ($urandom_range(2) != 0);
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            pix_taken <= i_valid && o_ready;
            if (i_valid && o_ready) add_pixel(i_data);
            if (o_valid && i_ready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %0d/%0d/%0d",
                        o_data.thresh_low, o_data.thresh_high, o_data.overflow));
                end else begin
                    if (o_data.thresh_low !== expected_q[0].thresh_low)
                        report_mismatch($sformatf("thresh_low %0d, expected %0d",
                            o_data.thresh_low, expected_q[0].thresh_low));
                    if (o_data.thresh_high !== expected_q[0].thresh_high)
                        report_mismatch($sformatf("thresh_high %0d, expected %0d",
                            o_data.thresh_high, expected_q[0].thresh_high));
                    if (o_data.overflow !== expected_q[0].overflow)
                        report_mismatch($sformatf("overflow %0d, expected %0d",
                            o_data.overflow, expected_q[0].overflow));
                    void'(expected_q.pop_front());
                end
            end
        end
    end

    initial begin
        #500_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        int lv[$];
        int n_items, len, w, base, distinct, n_wide;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_ready = 1'b0;
        i_data = '0;
        gap = 0;
        pix_taken = 0;
        out_busy_mode = 0;
        fail_count = 0;
        clear_histogram();

        // directed frames
        queue_frame('{0, 0, 0}, 0, 1);
        queue_frame('{255}, 0, 0);
        queue_frame('{0, 1, 255, 255, 1}, 0, 0);
        queue_frame('{0, 254, 255}, 0, 1);
        queue_frame('{253, 254, 255}, 0, 0);
        queue_frame('{0, 1, 2, 3}, 0, 0);
        queue_frame('{170, 85, 170, 85}, 0, 0);
        queue_frame('{100, 101, 102, 101, 100, 102}, 0, 1);

        // random frames, levels clustered so the search stays short;
        // at most two frames spread over the full range
        n_items = 0;
        n_wide = 0;
        while (n_items < 700) begin
            lv.delete();
            len = ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(16, 1);
            distinct = $urandom_range(9);
            if (distinct == 1) begin
                if (n_wide < 2) n_wide++;
                else distinct = 2;
            end
            if (distinct == 0) begin
                w = 0;
            end else if (distinct == 1) begin
                w = 1;
            end else begin
                w = $urandom_range(10, 2);
            end
            base = $urandom_range(255 - w);
            for (int k = 0; k < len; k++) begin
                if (distinct == 1 && $urandom_range(1)) lv.push_back($urandom_range(255));
                else lv.push_back(base + $urandom_range(w));
            end
            queue_frame(lv, $urandom_range(19) == 0, $urandom_range(3) == 0);
            n_items += len;
        end

        // last frame waits for every earlier result
        queue_frame('{3, 4, 5, 4}, 1, 0);

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        while (pending_q.size() != 0 || i_valid) @(posedge i_clk);
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
